[src/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // Lead byte boundaries
  localparam logic [7:0] LEAD_2B_MIN   = 8'h80;
  localparam logic [7:0] LEAD_3B_MIN   = 8'hE0;
  localparam logic [7:0] LEAD_4B_MIN   = 8'hF0;
  localparam logic [7:0] LEAD_BAD_MIN  = 8'hF8;

  localparam int unsigned CP_W = 21;

  // Emitted for a lead byte of 0xF8 and above
  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

  // Continuation bytes still expected
  typedef enum logic [1:0] {
    LEFT_NONE  = 2'd0,
    LEFT_ONE   = 2'd1,
    LEFT_TWO   = 2'd2,
    LEFT_THREE = 2'd3
  } left_t;

  // Input beat: one raw byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } byte_beat_t;

  // Output beat: one code point
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_code;
  } code_beat_t;

  // Sequence state carried from byte to byte
  typedef struct packed {
    left_t           bytes_left;
    logic [CP_W-1:0] partial_code;
  } seq_state_t;

endpackage

[src/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step
// Per-byte decode: next sequence state and the code point, if any.
// ----------------------------------------------------------------------------
module u8d_step (
  input  logic                utf8_mode,
  input  u8d_pkg::seq_state_t cur,
  input  u8d_pkg::byte_beat_t beat,
  output u8d_pkg::seq_state_t nxt,
  output logic                emit,
  output u8d_pkg::code_beat_t res
);
  import u8d_pkg::*;

  logic [7:0]      c;
  logic            eos;
  left_t           left_dec;
  logic [CP_W-1:0] cont_bits;
  logic [CP_W-1:0] merged;

  assign c   = beat.in_byte;
  assign eos = beat.end_of_string;

  // Continuation payload placed by the count still open after this byte
  always_comb begin
    left_dec = left_t'(cur.bytes_left - 2'd1);
    unique case (left_dec)
      LEFT_NONE: cont_bits = {15'd0, c[5:0]};
      LEFT_ONE:  cont_bits = {9'd0, c[5:0], 6'd0};
      LEFT_TWO:  cont_bits = {3'd0, c[5:0], 12'd0};
      default:   cont_bits = '0;
    endcase
    merged = cur.partial_code | cont_bits;
  end

  always_comb begin
    nxt            = cur;
    emit           = 1'b0;
    res.code_point = {13'd0, c};
    res.last_code  = eos;

    if (!utf8_mode) begin
      // pass-through drops any open sequence
      nxt  = '{bytes_left: LEFT_NONE, partial_code: '0};
      emit = 1'b1;
    end else if (cur.bytes_left == LEFT_NONE) begin
      // lead byte
      if (c < LEAD_2B_MIN) begin
        emit = 1'b1;
      end else if (c >= LEAD_BAD_MIN) begin
        emit           = 1'b1;
        res.code_point = CP_REPLACEMENT;
      end else begin
        if (c < LEAD_3B_MIN) begin
          nxt.bytes_left   = LEFT_ONE;
          nxt.partial_code = {10'd0, c[4:0], 6'd0};
        end else if (c < LEAD_4B_MIN) begin
          nxt.bytes_left   = LEFT_TWO;
          nxt.partial_code = {5'd0, c[3:0], 12'd0};
        end else begin
          nxt.bytes_left   = LEFT_THREE;
          nxt.partial_code = {c[2:0], 18'd0};
        end
        // cut short: flush the partial value
        if (eos) begin
          emit           = 1'b1;
          res.code_point = nxt.partial_code;
          nxt            = '{bytes_left: LEFT_NONE, partial_code: '0};
        end
      end
    end else begin
      // continuation byte, high bits not checked
      if (left_dec == LEFT_NONE || eos) begin
        emit           = 1'b1;
        res.code_point = merged;
        nxt            = '{bytes_left: LEFT_NONE, partial_code: '0};
      end else begin
        nxt.bytes_left   = left_dec;
        nxt.partial_code = merged;
      end
    end
  end

endmodule

[src/utf8_byte_stream_decoder.sv]
// Decode sits between the input register and the result register driving code_beat.
// Throughput: one byte per cycle while byte_stall is low.
// Bytes that leave a sequence open produce no beat.
// Reset (rst, synchronous): both stages empty, no open sequence, utf8_mode = 1.
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Byte stream to code point decoder with a UTF-8 / single-byte mode register.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                mode_wr_en,
  input  logic                mode_wr_data,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  u8d_pkg::byte_beat_t byte_beat,
  output logic                code_valid,
  input  logic                code_stall,
  output u8d_pkg::code_beat_t code_beat
);
  import u8d_pkg::*;

  logic       utf8_mode;
  logic       s1_valid;
  byte_beat_t s1_beat;
  seq_state_t seq;
  seq_state_t seq_next;
  logic       emit;
  code_beat_t res;
  logic       advance;
  logic       byte_take;

  // Decode of the registered byte
  u8d_step u_step (
    .utf8_mode (utf8_mode),
    .cur       (seq),
    .beat      (s1_beat),
    .nxt       (seq_next),
    .emit      (emit),
    .res       (res)
  );

  // Stage 1 moves on unless it has a result and the result register is held
  assign advance    = s1_valid && !(emit && code_valid && code_stall);
  assign byte_stall = s1_valid && !advance;
  assign byte_take  = byte_valid && !byte_stall;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_mode <= 1'b1;
    end else if (mode_wr_en) begin
      utf8_mode <= mode_wr_data;
    end
  end

  // Input register and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      seq      <= '{bytes_left: LEFT_NONE, partial_code: '0};
    end else begin
      s1_valid <= byte_take || (s1_valid && !advance);
      if (advance) begin
        seq <= seq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      s1_beat <= byte_beat;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (advance && emit) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      code_beat <= res;
    end
  end

endmodule

[src/u8d_checker.sv]
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_stall,
  input logic                code_valid,
  input logic                code_stall,
  input u8d_pkg::code_beat_t code_beat
);
  import u8d_pkg::*;

  // Result beat stays up while held
  a_code_valid_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid)
    else $error("code_valid dropped while stalled");

  // Held result beat keeps its value
  a_code_beat_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> $stable(code_beat))
    else $error("code_beat changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !code_valid)
    else $error("code_valid high after reset");

  // Input is only held back when a result is waiting and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> code_valid && code_stall)
    else $error("byte_stall without a held result");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_stall (byte_stall),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code_beat  (code_beat)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 byte stream decoder: a queue-fed byte
// driver, a code point monitor that checks each beat against a local decoder
// model, random idling on both sides and mode changes between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import u8d_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;  // cycles with no beat on either side
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned SETTLE      = 6;     // covers the two-stage pipeline
  localparam int unsigned MAX_PRINTS  = 25;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       mode_wr_en   = 1'b0;
  logic       mode_wr_data = 1'b0;
  logic       byte_valid   = 1'b0;
  logic       byte_stall;
  byte_beat_t byte_beat    = '0;
  logic       code_valid;
  logic       code_stall   = 1'b0;
  code_beat_t code_beat;

  utf8_byte_stream_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .mode_wr_en   (mode_wr_en),
    .mode_wr_data (mode_wr_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_beat    (code_beat)
  );

  always #5 clk = ~clk;

  // Pending bytes and expected code points
  byte_beat_t  byte_q[$];
  code_beat_t  exp_codes[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned codes_seen   = 0;
  int unsigned mode_writes  = 0;
  int unsigned err_count    = 0;

  // Idle controls, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_asked    = 0;

  // Decoder model state
  logic            utf8_on  = 1'b1;
  left_t           seq_left = LEFT_NONE;
  logic [CP_W-1:0] seq_part = '0;

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Model of one byte; returns 1 when the byte yields a code point
  function automatic bit decode_byte(input byte_beat_t b, output code_beat_t r);
    logic [7:0] c;
    logic       eos;
    c   = b.in_byte;
    eos = b.end_of_string;
    r   = '0;
    // pass-through mode drops any open sequence
    if (!utf8_on) begin
      seq_left     = LEFT_NONE;
      seq_part     = '0;
      r.code_point = CP_W'(c);
      r.last_code  = eos;
      return 1'b1;
    end
    // lead byte
    if (seq_left == LEFT_NONE) begin
      if (c < LEAD_2B_MIN) begin
        r.code_point = CP_W'(c);
        r.last_code  = eos;
        return 1'b1;
      end else if (c < LEAD_3B_MIN) begin
        seq_part = CP_W'(c[4:0]) << 6;
        seq_left = LEFT_ONE;
      end else if (c < LEAD_4B_MIN) begin
        seq_part = CP_W'(c[3:0]) << 12;
        seq_left = LEFT_TWO;
      end else if (c < LEAD_BAD_MIN) begin
        seq_part = CP_W'(c[2:0]) << 18;
        seq_left = LEFT_THREE;
      end else begin
        r.code_point = CP_REPLACEMENT;
        r.last_code  = eos;
        return 1'b1;
      end
      // string ends right on the lead: emit what we have
      if (eos) begin
        r.code_point = seq_part;
        r.last_code  = 1'b1;
        seq_left     = LEFT_NONE;
        seq_part     = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    // follow-on byte, high bits ignored
    seq_left = left_t'(seq_left - 2'd1);
    seq_part = seq_part | (CP_W'(c[5:0]) << (6 * seq_left));
    if (seq_left == LEFT_NONE || eos) begin
      r.code_point = seq_part;
      r.last_code  = eos;
      seq_left     = LEFT_NONE;
      seq_part     = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Byte driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin
    code_beat_t cb;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        bytes_taken++;
        if (decode_byte(byte_beat, cb)) exp_codes = {exp_codes, cb};
      end
      if (!byte_valid || !byte_stall) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_beat  <= byte_q.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Code point monitor and receiver stall
  always @(posedge clk) begin
    code_beat_t  want;
    int unsigned hold_left;
    int unsigned hold_done;
    if (rst) begin
      code_stall <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (code_valid && !code_stall) begin
        codes_seen++;
        if (exp_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected code point %06h last %0b",
                                    code_beat.code_point, code_beat.last_code));
        end else begin
          want = exp_codes.pop_front();
          if (code_beat.code_point !== want.code_point)
            report_mismatch($sformatf("code_point got %06h want %06h",
                                      code_beat.code_point, want.code_point));
          if (code_beat.last_code !== want.last_code)
            report_mismatch($sformatf("last_code got %0b want %0b on %06h",
                                      code_beat.last_code, want.last_code,
                                      want.code_point));
        end
      end
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        code_stall <= 1'b1;
      end else begin
        code_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on beats in either direction
  always @(posedge clk) begin
    int unsigned quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      if ((byte_valid && !byte_stall) || (code_valid && !code_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[%0t] timeout: no beat for %0d cycles", $realtime, quiet);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    byte_beat_t x;
    x.in_byte       = b;
    x.end_of_string = eos;
    byte_q = {byte_q, x};
    bytes_queued++;
  endtask

  // Lead plus follow-on bytes, mostly well formed
  task automatic push_seq(input logic [7:0] lead, input int unsigned ncont, input logic eos);
    logic [7:0] b;
    push_byte(lead, eos && ncont == 0);
    for (int unsigned i = 1; i <= ncont; i++) begin
      if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
      else b = 8'h80 | 8'($urandom_range(63));
      push_byte(b, eos && i == ncont);
    end
  endtask

  task automatic queue_sequence();
    int unsigned kind;
    int unsigned seq_len;
    logic [7:0]  lead;
    logic        eos_end;
    kind    = $urandom_range(99);
    eos_end = ($urandom_range(7) == 0);
    if (!utf8_on) begin
      push_byte(8'($urandom_range(255)), eos_end);
    end else if (kind < 25) begin
      push_byte(8'($urandom_range(8'h7F, 8'h00)), eos_end);
    end else if (kind < 45) begin
      push_seq(8'($urandom_range(8'hDF, 8'h80)), 1, eos_end);
    end else if (kind < 65) begin
      push_seq(8'($urandom_range(8'hEF, 8'hE0)), 2, eos_end);
    end else if (kind < 82) begin
      push_seq(8'($urandom_range(8'hF7, 8'hF0)), 3, eos_end);
    end else if (kind < 88) begin
      push_byte(8'($urandom_range(8'hFF, 8'hF8)), eos_end);
    end else if (kind < 95) begin
      // cut short by the end of the string
      seq_len = $urandom_range(4, 2);
      case (seq_len)
        2:       lead = 8'($urandom_range(8'hDF, 8'h80));
        3:       lead = 8'($urandom_range(8'hEF, 8'hE0));
        default: lead = 8'($urandom_range(8'hF7, 8'hF0));
      endcase
      push_seq(lead, $urandom_range(seq_len - 2, 0), 1'b1);
    end else begin
      push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < n) queue_sequence();
  endtask

  // Everything accepted, every code point back, pipeline flushed
  task automatic wait_idle();
    do @(negedge clk); while (bytes_taken != bytes_queued || exp_codes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(posedge clk);
    mode_wr_en   <= 1'b1;
    mode_wr_data <= v;
    @(posedge clk);
    mode_wr_en <= 1'b0;
    utf8_on = v;
    mode_writes++;
  endtask

  task automatic run_phase(input logic mode, input int unsigned idle_s,
                           input int unsigned idle_r, input int unsigned n);
    write_mode(mode);
    send_idle_pct = idle_s;
    stall_pct     = idle_r;
    queue_random(n);
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: UTF-8 mode from reset
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h80, 1'b0);  push_byte(8'hBF, 1'b0);
    push_byte(8'hDF, 1'b0);  push_byte(8'h7F, 1'b0);   // follow-on not 10xxxxxx
    push_byte(8'hE2, 1'b0);  push_byte(8'h82, 1'b0);  push_byte(8'hAC, 1'b0);
    push_byte(8'hEF, 1'b0);  push_byte(8'hFF, 1'b0);  push_byte(8'hFF, 1'b1);
    push_byte(8'hF7, 1'b0);  push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);  push_byte(8'hBF, 1'b0);
    push_byte(8'hF8, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hE2, 1'b1);                             // end on the lead
    push_byte(8'hF4, 1'b0);  push_byte(8'h8F, 1'b1);   // end mid-sequence
    push_byte(8'hC3, 1'b0);                             // left open
    wait_idle();

    // Open sequence dropped by the switch to single-byte mode
    write_mode(1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Random phases across idle patterns and modes
    run_phase(1'b1, 0, 0, 300);
    run_phase(1'b1, 66, 0, 250);
    run_phase(1'b0, 0, 66, 150);

    // Sender pauses mid-phase until all code points are back
    write_mode(1'b1);
    send_idle_pct = 36;
    stall_pct     = 36;
    queue_random(120);
    wait_idle();
    queue_random(130);
    wait_idle();

    // Long receiver hold-off with the sender pushing
    write_mode(1'b1);
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random(250);
    hold_asked++;
    wait_idle();

    run_phase(1'b1, 0, 66, 250);
    run_phase(1'b0, 66, 0, 100);

    repeat (SETTLE) @(posedge clk);
    if (exp_codes.size() != 0)
      report_mismatch($sformatf("%0d code points never arrived", exp_codes.size()));

    $display("Covered %0d bytes and %0d code points over %0d mode writes,",
             bytes_taken, codes_seen, mode_writes);
    $display("both modes, truncated and invalid sequences, idle and stall patterns.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
